// ===== hdl/grc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_pkg: shared types and constants of the column raycaster
// Holds the stream widths, register and function codes, and the fixed
// widths of the shared divider and multiplier.
// ----------------------------------------------------------------------------
package grc_pkg;

    // Shared divider: numerator and denominator widths.
    localparam int DIV_NW = 44;
    localparam int DIV_DW = 32;
    localparam int DIV_CW = $clog2(DIV_NW);

    // Shared multiplier: signed operand and product widths.
    localparam int MUL_AW = 25;
    localparam int MUL_BW = 33;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // Stream and configuration widths.
    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 136;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

    localparam logic FUNC_MAP_WRITE = 1'b0;
    localparam logic FUNC_CAST      = 1'b1;

    localparam logic [1:0] FACE_NORTH = 2'd0;
    localparam logic [1:0] FACE_SOUTH = 2'd1;
    localparam logic [1:0] FACE_WEST  = 2'd2;
    localparam logic [1:0] FACE_EAST  = 2'd3;

    localparam logic [31:0] DELTA_MAX = 32'hFFFF_FFFF;
    localparam logic [23:0] DIST_MAX  = 24'hFF_FFFF;
    localparam logic [15:0] LH_MAX    = 16'hFFFF;
    localparam logic [22:0] Q23_MAX   = 23'h7F_FFFF;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== hdl/grc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_div: shared restoring divider
// Produces one quotient bit per cycle. A zero divisor gives an all-ones
// quotient, which the caller's saturation turns into the wanted limit.
// ----------------------------------------------------------------------------
module grc_div
    import grc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  div_req_t          req_i,
    output div_stat_t         stat_o,
    output logic [DIV_NW-1:0] quo_o
);

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_NW-1:0] num_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] den_reg;

    logic [DIV_DW:0]   rem_shift;
    logic              ge;
    logic [DIV_DW:0]   rem_diff;

    always_comb begin
        rem_shift = {rem_reg, num_reg[DIV_NW-1]};
        ge        = rem_shift >= {1'b0, den_reg};
        rem_diff  = rem_shift - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req_i.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CW'(DIV_NW - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req_i.start) begin
            num_reg <= req_i.num;
            den_reg <= req_i.den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[DIV_NW-2:0], ge};
            rem_reg <= ge ? rem_diff[DIV_DW-1:0] : rem_shift[DIV_DW-1:0];
        end
    end

    assign stat_o.busy = busy_reg;
    assign stat_o.done = done_reg;
    assign quo_o       = num_reg;

endmodule

// ===== hdl/grc_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_mul: shared signed multiplier
// One signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module grc_mul
    import grc_pkg::*;
(
    input  logic                     aclk,
    input  logic signed [MUL_AW-1:0] a_i,
    input  logic signed [MUL_BW-1:0] b_i,
    output logic signed [MUL_PW-1:0] p_o
);

    logic signed [MUL_PW-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= MUL_PW'(a_i) * MUL_PW'(b_i);
    end

    assign p_o = p_reg;

endmodule

// ===== hdl/grc_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_map: one-bit wall map memory
// Single write port, one registered read port, and a clearing pass after
// reset that writes every entry open, one per cycle.
// ----------------------------------------------------------------------------
module grc_map
    import grc_pkg::*;
#(
    parameter int AW = 12
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en_i,
    input  logic [AW-1:0] wr_addr_i,
    input  logic          wr_data_i,
    input  logic [AW-1:0] rd_addr_i,
    output logic          rd_data_o,
    output logic          clearing_o
);

    localparam int DEPTH = 1 << AW;

    logic          mem [0:DEPTH-1];
    logic          clearing_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clr_addr_reg] <= 1'b0;
        end else if (wr_en_i) begin
            mem[wr_addr_i] <= wr_data_i;
        end
        rd_data_reg <= mem[rd_addr_i];
    end

    assign rd_data_o  = rd_data_reg;
    assign clearing_o = clearing_reg;

endmodule

// ===== hdl/grid_raycast_column.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_raycast_column: column raycaster over a one-bit wall map
// Map writes and grid-stepping ray casts for one screen column per transaction.
// ----------------------------------------------------------------------------
// After reset the block clears its wall map, one entry per cycle, and s_tready
// stays low until that pass is over. A map-write transaction (tuser 0) gives
// no result. A cast transaction (tuser 1) runs under a small sequencer that
// drives one shared restoring divider and one shared multiplier. It makes six
// divisions (camera coordinate, two ray deltas, distance, line height, texture
// step) and a grid walk that waits on a registered map read for each cell
// crossed, with at most 2*MAP_SIZE+2 cells. The result sits in an output
// register, so the next transaction is taken while the previous result waits
// for m_tready. Configuration writes are taken at once and must only be issued
// while the block is idle.
// ----------------------------------------------------------------------------
module grid_raycast_column
    import grc_pkg::*;
#(
    parameter int MAP_SIZE = 64,
    parameter int TEX_SIZE = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // tdata from bit 0: column(12) pos_x(22) pos_y(22) dir_x(18) dir_y(18)
    // plane_x(18) plane_y(18) cell_x(6) cell_y(6) cell_wall(1), zero padded
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // tuser: func(1)
    input  logic                   s_tuser,
    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // tdata from bit 0: hit_side(1) wall_face(2) hit_x(6) hit_y(6)
    // wall_distance(24) stripe_height(16) span_top(12) span_bottom(12)
    // tex_column(6) tex_step(23) tex_start(23), zero padded
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // tuser: no_hit(1)
    output logic                   m_tuser,
    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int MW    = $clog2(MAP_SIZE);
    localparam int CW    = (MW > 6 ? MW : 6) + 2;
    localparam int AW    = 2 * MW;
    localparam int LIMIT = 2 * MAP_SIZE + 2;
    localparam int SW    = $clog2(LIMIT + 1);
    localparam int SDW   = 43;
    localparam int RW    = 33;
    localparam int NUMW  = CW + 18;
    localparam int TW    = 8;

    // Sequencer state codes.
    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_CAM_GO  = 5'd1;
    localparam logic [4:0] ST_CAM_W   = 5'd2;
    localparam logic [4:0] ST_RX_M    = 5'd3;
    localparam logic [4:0] ST_RX_T    = 5'd4;
    localparam logic [4:0] ST_RY_T    = 5'd5;
    localparam logic [4:0] ST_DX_GO   = 5'd6;
    localparam logic [4:0] ST_DX_W    = 5'd7;
    localparam logic [4:0] ST_DY_GO   = 5'd8;
    localparam logic [4:0] ST_DY_W    = 5'd9;
    localparam logic [4:0] ST_SX_M    = 5'd10;
    localparam logic [4:0] ST_SX_T    = 5'd11;
    localparam logic [4:0] ST_SY_T    = 5'd12;
    localparam logic [4:0] ST_STEP    = 5'd13;
    localparam logic [4:0] ST_CHK     = 5'd14;
    localparam logic [4:0] ST_DIST_GO = 5'd15;
    localparam logic [4:0] ST_DIST_W  = 5'd16;
    localparam logic [4:0] ST_LH_GO   = 5'd17;
    localparam logic [4:0] ST_LH_W    = 5'd18;
    localparam logic [4:0] ST_TEX_M   = 5'd19;
    localparam logic [4:0] ST_TEX_T   = 5'd20;
    localparam logic [4:0] ST_TS_GO   = 5'd21;
    localparam logic [4:0] ST_TS_W    = 5'd22;
    localparam logic [4:0] ST_TSM_M   = 5'd23;
    localparam logic [4:0] ST_TSM_T   = 5'd24;
    localparam logic [4:0] ST_EMIT    = 5'd25;
    localparam logic [4:0] ST_NOHIT   = 5'd26;

    // Input field views.
    logic [11:0]        in_column;
    logic [21:0]        in_pos_x;
    logic [21:0]        in_pos_y;
    logic signed [17:0] in_dir_x;
    logic signed [17:0] in_dir_y;
    logic signed [17:0] in_plane_x;
    logic signed [17:0] in_plane_y;
    logic [5:0]         in_cell_x;
    logic [5:0]         in_cell_y;
    logic               in_cell_wall;

    assign in_column    = s_tdata[11:0];
    assign in_pos_x     = s_tdata[33:12];
    assign in_pos_y     = s_tdata[55:34];
    assign in_dir_x     = s_tdata[73:56];
    assign in_dir_y     = s_tdata[91:74];
    assign in_plane_x   = s_tdata[109:92];
    assign in_plane_y   = s_tdata[127:110];
    assign in_cell_x    = s_tdata[133:128];
    assign in_cell_y    = s_tdata[139:134];
    assign in_cell_wall = s_tdata[140];

    // Configuration registers.
    logic [12:0] screen_width_reg;
    logic [12:0] screen_height_reg;
    logic [12:0] width_eff;

    assign cfg_ready = 1'b1;
    assign width_eff = (screen_width_reg == '0) ? 13'd1 : screen_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= 13'd640;
            screen_height_reg <= 13'd480;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and datapath registers.
    logic [4:0]             state_reg;
    logic [4:0]             state_next;

    logic [11:0]            col_reg;
    logic [21:0]            px_reg;
    logic [21:0]            py_reg;
    logic signed [17:0]     dx_reg;
    logic signed [17:0]     dy_reg;
    logic signed [17:0]     plx_reg;
    logic signed [17:0]     ply_reg;
    logic signed [RW-1:0]   cam_reg;
    logic signed [RW-1:0]   rx_reg;
    logic signed [RW-1:0]   ry_reg;
    logic [31:0]            ddx_reg;
    logic [31:0]            ddy_reg;
    logic [SDW-1:0]         sdx_reg;
    logic [SDW-1:0]         sdy_reg;
    logic signed [CW-1:0]   mx_reg;
    logic signed [CW-1:0]   my_reg;
    logic                   side_reg;
    logic [SW-1:0]          steps_reg;
    logic [23:0]            dist_reg;
    logic [15:0]            lh_reg;
    logic [TW-1:0]          tex_reg;
    logic [22:0]            step_reg;
    logic [22:0]            tstart_reg;
    logic [11:0]            dstart_reg;
    logic [11:0]            dend_reg;
    logic [15:0]            diff_reg;

    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tuser_reg;

    // Shared units.
    div_req_t                 div_req;
    div_stat_t                div_stat;
    logic [DIV_NW-1:0]        div_quo;
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [MUL_PW-1:0] mul_p;

    grc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_i   (div_req),
        .stat_o  (div_stat),
        .quo_o   (div_quo)
    );

    grc_mul u_mul (
        .aclk (aclk),
        .a_i  (mul_a),
        .b_i  (mul_b),
        .p_o  (mul_p)
    );

    // Wall map.
    logic          map_wr_en;
    logic [AW-1:0] map_wr_addr;
    logic [AW-1:0] map_rd_addr;
    logic          map_rd_data;
    logic          map_clearing;
    logic [CW-1:0] wr_cx;
    logic [CW-1:0] wr_cy;

    grc_map #(
        .AW (AW)
    ) u_map (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en_i    (map_wr_en),
        .wr_addr_i  (map_wr_addr),
        .wr_data_i  (in_cell_wall),
        .rd_addr_i  (map_rd_addr),
        .rd_data_o  (map_rd_data),
        .clearing_o (map_clearing)
    );

    logic s_accept;

    assign s_tready  = (state_reg == ST_IDLE) && !map_clearing;
    assign s_accept  = s_tvalid && s_tready;
    assign wr_cx     = CW'(in_cell_x);
    assign wr_cy     = CW'(in_cell_y);
    // Writes to cells beyond the map are dropped.
    assign map_wr_en = s_accept && (s_tuser == FUNC_MAP_WRITE)
                       && (wr_cx < CW'(MAP_SIZE)) && (wr_cy < CW'(MAP_SIZE));
    assign map_wr_addr = {wr_cx[MW-1:0], wr_cy[MW-1:0]};

    // Ray magnitudes, step directions and cell fractions.
    logic [31:0] rx_mag;
    logic [31:0] ry_mag;
    logic        rx_neg;
    logic        ry_neg;
    logic [16:0] frac_x;
    logic [16:0] frac_y;

    always_comb begin
        rx_neg = rx_reg[RW-1];
        ry_neg = ry_reg[RW-1];
        rx_mag = rx_neg ? 32'(-rx_reg) : 32'(rx_reg);
        ry_mag = ry_neg ? 32'(-ry_reg) : 32'(ry_reg);
        frac_x = rx_neg ? {1'b0, px_reg[15:0]} : 17'h10000 - {1'b0, px_reg[15:0]};
        frac_y = ry_neg ? {1'b0, py_reg[15:0]} : 17'h10000 - {1'b0, py_reg[15:0]};
    end

    // One grid step: advance along the axis whose side distance is smaller.
    logic signed [CW-1:0] mx_step;
    logic signed [CW-1:0] my_step;
    logic [SDW-1:0]       sdx_step;
    logic [SDW-1:0]       sdy_step;
    logic                 side_step;
    logic                 step_oob;

    always_comb begin
        mx_step   = mx_reg;
        my_step   = my_reg;
        sdx_step  = sdx_reg;
        sdy_step  = sdy_reg;
        side_step = 1'b1;
        if (sdx_reg < sdy_reg) begin
            sdx_step  = sdx_reg + SDW'(ddx_reg);
            mx_step   = rx_neg ? mx_reg - 1'b1 : mx_reg + 1'b1;
            side_step = 1'b0;
        end else begin
            sdy_step = sdy_reg + SDW'(ddy_reg);
            my_step  = ry_neg ? my_reg - 1'b1 : my_reg + 1'b1;
        end
        step_oob = mx_step[CW-1] || my_step[CW-1]
                   || (mx_step >= $signed(CW'(MAP_SIZE)))
                   || (my_step >= $signed(CW'(MAP_SIZE)));
    end

    assign map_rd_addr = {mx_step[MW-1:0], my_step[MW-1:0]};

    // Offset from the viewer to the crossed grid line on the hit side.
    logic signed [NUMW-1:0] line_num;
    logic [NUMW-1:0]        line_mag;
    logic signed [CW-1:0]   hit_coord;
    logic [21:0]            hit_pos;
    logic                   hit_neg;

    always_comb begin
        hit_coord = side_reg ? my_reg : mx_reg;
        hit_pos   = side_reg ? py_reg : px_reg;
        hit_neg   = side_reg ? ry_neg : rx_neg;
        line_num  = (NUMW'(hit_coord) <<< 16) - $signed(NUMW'(hit_pos))
                    + (hit_neg ? $signed(NUMW'(32'h10000)) : $signed(NUMW'(0)));
        line_mag  = line_num[NUMW-1] ? NUMW'(-line_num) : NUMW'(line_num);
    end

    // Texture column from the fraction of the wall hit coordinate, which runs
    // along the wall: y for an x-side, x for a y-side.
    logic [15:0]   wall_frac;
    logic [31:0]   tex_prod;
    logic [TW-1:0] tex_raw;
    logic          tex_mirror;

    always_comb begin
        wall_frac  = (side_reg ? px_reg[15:0] : py_reg[15:0]) + mul_p[31:16];
        tex_prod   = {16'b0, wall_frac} * 32'(TEX_SIZE);
        tex_raw    = tex_prod[23:16];
        tex_mirror = (!side_reg && !rx_neg && (rx_reg != '0)) || (side_reg && ry_neg);
    end

    // Draw span from line height and screen height.
    logic signed [17:0] half_h;
    logic signed [17:0] half_lh;
    logic signed [17:0] span_start;
    logic signed [17:0] span_end;
    logic signed [17:0] span_diff;

    always_comb begin
        half_h     = 18'(screen_height_reg[12:1]);
        half_lh    = 18'(lh_reg[15:1]);
        span_start = half_h - half_lh;
        if (span_start < 0) begin
            span_start = '0;
        end
        span_end = half_lh + half_h;
        if (screen_height_reg == '0) begin
            span_end = '0;
        end else if (span_end >= 18'(screen_height_reg)) begin
            span_end = 18'(screen_height_reg) - 18'sd1;
        end
        span_diff = span_start - half_h + half_lh;
    end

    // Shared unit operand selection.
    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        mul_a         = '0;
        mul_b         = '0;
        unique case (state_reg)
            ST_CAM_GO: begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'({col_reg, 17'b0});
                div_req.den   = DIV_DW'(width_eff);
            end
            ST_DX_GO: begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'(1) << 32;
                div_req.den   = rx_mag;
            end
            ST_DY_GO: begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'(1) << 32;
                div_req.den   = ry_mag;
            end
            ST_DIST_GO: begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'({line_mag, 16'b0});
                div_req.den   = side_reg ? ry_mag : rx_mag;
            end
            ST_LH_GO: begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'({screen_height_reg, 16'b0});
                div_req.den   = DIV_DW'(dist_reg);
            end
            ST_TS_GO: begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'(TEX_SIZE) << 16;
                div_req.den   = DIV_DW'(lh_reg);
            end
            ST_RX_M: begin
                mul_a = MUL_AW'(plx_reg);
                mul_b = cam_reg;
            end
            ST_RX_T: begin
                mul_a = MUL_AW'(ply_reg);
                mul_b = cam_reg;
            end
            ST_SX_M: begin
                mul_a = $signed(MUL_AW'(frac_x));
                mul_b = $signed({1'b0, ddx_reg});
            end
            ST_SX_T: begin
                mul_a = $signed(MUL_AW'(frac_y));
                mul_b = $signed({1'b0, ddy_reg});
            end
            ST_TEX_M: begin
                mul_a = $signed(MUL_AW'(dist_reg));
                mul_b = side_reg ? rx_reg : ry_reg;
            end
            ST_TSM_M: begin
                mul_a = $signed(MUL_AW'(diff_reg));
                mul_b = $signed(MUL_BW'(step_reg));
            end
            default: ;
        endcase
    end

    // Next state.
    logic out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_tuser == FUNC_CAST) begin
                    state_next = ST_CAM_GO;
                end
            end
            ST_CAM_GO:  state_next = ST_CAM_W;
            ST_CAM_W:   if (div_stat.done) state_next = ST_RX_M;
            ST_RX_M:    state_next = ST_RX_T;
            ST_RX_T:    state_next = ST_RY_T;
            ST_RY_T:    state_next = ST_DX_GO;
            ST_DX_GO:   state_next = ST_DX_W;
            ST_DX_W:    if (div_stat.done) state_next = ST_DY_GO;
            ST_DY_GO:   state_next = ST_DY_W;
            ST_DY_W:    if (div_stat.done) state_next = ST_SX_M;
            ST_SX_M:    state_next = ST_SX_T;
            ST_SX_T:    state_next = ST_SY_T;
            ST_SY_T: begin
                // A viewer outside the map never reaches a wall.
                if ((mx_reg >= $signed(CW'(MAP_SIZE)))
                        || (my_reg >= $signed(CW'(MAP_SIZE)))) begin
                    state_next = ST_NOHIT;
                end else begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:    state_next = step_oob ? ST_NOHIT : ST_CHK;
            ST_CHK: begin
                if (map_rd_data) begin
                    state_next = ST_DIST_GO;
                end else if (steps_reg == SW'(LIMIT)) begin
                    state_next = ST_NOHIT;
                end else begin
                    state_next = ST_STEP;
                end
            end
            ST_DIST_GO: state_next = ST_DIST_W;
            ST_DIST_W:  if (div_stat.done) state_next = ST_LH_GO;
            ST_LH_GO:   state_next = ST_LH_W;
            ST_LH_W:    if (div_stat.done) state_next = ST_TEX_M;
            ST_TEX_M:   state_next = ST_TEX_T;
            ST_TEX_T:   state_next = ST_TS_GO;
            ST_TS_GO:   state_next = ST_TS_W;
            ST_TS_W:    if (div_stat.done) state_next = ST_TSM_M;
            ST_TSM_M:   state_next = ST_TSM_T;
            ST_TSM_T:   state_next = ST_EMIT;
            ST_EMIT:    if (out_free) state_next = ST_IDLE;
            ST_NOHIT:   if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    col_reg   <= in_column;
                    px_reg    <= in_pos_x;
                    py_reg    <= in_pos_y;
                    dx_reg    <= in_dir_x;
                    dy_reg    <= in_dir_y;
                    plx_reg   <= in_plane_x;
                    ply_reg   <= in_plane_y;
                    mx_reg    <= $signed(CW'(in_pos_x[21:16]));
                    my_reg    <= $signed(CW'(in_pos_y[21:16]));
                    steps_reg <= '0;
                    side_reg  <= 1'b0;
                end
            end
            ST_CAM_W: begin
                if (div_stat.done) begin
                    cam_reg <= $signed(RW'(div_quo)) - $signed(RW'(32'h10000));
                end
            end
            ST_RX_T:  rx_reg <= RW'(dx_reg) + RW'(mul_p >>> 16);
            ST_RY_T:  ry_reg <= RW'(dy_reg) + RW'(mul_p >>> 16);
            ST_DX_W: begin
                if (div_stat.done) begin
                    ddx_reg <= (div_quo > DIV_NW'(DELTA_MAX)) ? DELTA_MAX : div_quo[31:0];
                end
            end
            ST_DY_W: begin
                if (div_stat.done) begin
                    ddy_reg <= (div_quo > DIV_NW'(DELTA_MAX)) ? DELTA_MAX : div_quo[31:0];
                end
            end
            ST_SX_T:  sdx_reg <= SDW'(mul_p[MUL_PW-1:16]);
            ST_SY_T:  sdy_reg <= SDW'(mul_p[MUL_PW-1:16]);
            ST_STEP: begin
                mx_reg    <= mx_step;
                my_reg    <= my_step;
                sdx_reg   <= sdx_step;
                sdy_reg   <= sdy_step;
                side_reg  <= side_step;
                steps_reg <= steps_reg + 1'b1;
            end
            ST_DIST_W: begin
                if (div_stat.done) begin
                    dist_reg <= (div_quo > DIV_NW'(DIST_MAX)) ? DIST_MAX : div_quo[23:0];
                end
            end
            ST_LH_W: begin
                if (div_stat.done) begin
                    lh_reg <= (div_quo > DIV_NW'(LH_MAX)) ? LH_MAX : div_quo[15:0];
                end
            end
            ST_TEX_T: begin
                tex_reg <= tex_mirror ? TW'(TEX_SIZE - 1) - tex_raw : tex_raw;
            end
            ST_TS_GO: begin
                dstart_reg <= span_start[11:0];
                dend_reg   <= span_end[11:0];
                diff_reg   <= span_diff[15:0];
            end
            ST_TS_W: begin
                if (div_stat.done) begin
                    step_reg <= (div_quo > DIV_NW'(Q23_MAX)) ? Q23_MAX : div_quo[22:0];
                end
            end
            ST_TSM_T: begin
                tstart_reg <= (mul_p > $signed(MUL_PW'(Q23_MAX))) ? Q23_MAX
                              : mul_p[22:0];
            end
            default: ;
        endcase
    end

    // Face from the side crossed last and the sign of the ray on that axis.
    logic [1:0] face;

    assign face = side_reg ? (ry_neg ? FACE_NORTH : FACE_SOUTH)
                           : (rx_neg ? FACE_EAST : FACE_WEST);

    // Output register: holds one result while the next transaction proceeds.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((state_reg == ST_EMIT || state_reg == ST_NOHIT) && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EMIT && out_free) begin
            m_tuser_reg <= 1'b0;
            m_tdata_reg <= OUT_TDATA_W'({tstart_reg, step_reg, tex_reg[5:0],
                                         dend_reg, dstart_reg, lh_reg, dist_reg,
                                         my_reg[5:0], mx_reg[5:0], face, side_reg});
        end else if (state_reg == ST_NOHIT && out_free) begin
            // A miss reports nothing but the flag.
            m_tuser_reg <= 1'b1;
            m_tdata_reg <= '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The map clearing pass blocks input transactions.
    a_no_accept_while_clearing: assert property (
        @(posedge aclk) disable iff (!aresetn) map_clearing |-> !s_tready
    ) else $error("input accepted during map clearing pass");

    // The grid walk never runs past its step limit.
    a_walk_bounded: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHK) |-> (steps_reg <= SW'(LIMIT))
    ) else $error("grid walk exceeded its step limit");

    // A division is only started on an idle divider.
    a_div_free: assert property (
        @(posedge aclk) disable iff (!aresetn) div_req.start |-> !div_stat.busy
    ) else $error("divider restarted while busy");

    // A miss result carries all-zero fields.
    a_miss_zero: assert property (
        @(posedge aclk) disable iff (!aresetn) (m_tvalid && m_tuser) |-> (m_tdata == '0)
    ) else $error("miss result with non-zero fields");

endmodule
